>>> hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Command codes, payload structs and the per-stage record of the divide chain.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FracBits = 8;
    localparam int DataW    = 32;
    localparam int NumW     = DataW + FracBits;   // dividend width
    localparam int Stages   = NumW;               // one quotient bit per cell

    localparam logic [3:0] CMD_ADD  = 4'd0;
    localparam logic [3:0] CMD_SUB  = 4'd1;
    localparam logic [3:0] CMD_MUL  = 4'd2;
    localparam logic [3:0] CMD_DIV  = 4'd3;
    localparam logic [3:0] CMD_GT   = 4'd4;
    localparam logic [3:0] CMD_LT   = 4'd5;
    localparam logic [3:0] CMD_GE   = 4'd6;
    localparam logic [3:0] CMD_LE   = 4'd7;
    localparam logic [3:0] CMD_EQ   = 4'd8;
    localparam logic [3:0] CMD_NE   = 4'd9;
    localparam logic [3:0] CMD_MIN  = 4'd10;
    localparam logic [3:0] CMD_MAX  = 4'd11;
    localparam logic [3:0] CMD_INC  = 4'd12;
    localparam logic [3:0] CMD_DEC  = 4'd13;
    localparam logic [3:0] CMD_FINT = 4'd14;
    localparam logic [3:0] CMD_TINT = 4'd15;

    typedef struct packed {
        logic        [3:0]       command;
        logic signed [DataW-1:0] operand_a;
        logic signed [DataW-1:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic signed [DataW-1:0] result;
        logic                    truth;
        logic                    divide_by_zero;
    } t_out_beat;

    // Record handed from cell to cell.
    typedef struct packed {
        logic                    vld;
        logic                    is_div;
        logic                    neg;       // quotient sign
        logic                    dz;
        logic        [DataW-1:0] res;       // finished result for non-divide
        logic                    truth;
        logic        [DataW-1:0] div;       // |b|
        logic        [DataW:0]   rem;       // partial remainder
        logic        [NumW-1:0]  num;       // dividend, shifted left, quotient in low bits
    } t_cell;

endpackage

>>> hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: first cell, decode and the non-divide operations
// Computes every non-divide result and prepares the divide operands.
// ----------------------------------------------------------------------------
module fpa_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  fpa_pkg::t_in_beat i_beat,
    output fpa_pkg::t_cell   o_cell
);
    import fpa_pkg::*;

    logic signed [DataW-1:0]   a, b;
    logic signed [2*DataW-1:0] prod;
    logic signed [2*DataW-1:0] prod_sh;
    logic        [DataW-1:0]   abs_a, abs_b;
    t_cell                     n_cell, r_cell;

    assign a = i_beat.operand_a;
    assign b = i_beat.operand_b;
    assign prod    = a * b;
    assign prod_sh = prod >>> FracBits;
    assign abs_a   = a[DataW-1] ? (~a + 1'b1) : a;
    assign abs_b   = b[DataW-1] ? (~b + 1'b1) : b;

    always_comb begin
        n_cell        = '0;
        n_cell.vld    = i_vld;
        n_cell.div    = abs_b;
        n_cell.num    = {abs_a, {FracBits{1'b0}}};
        n_cell.neg    = a[DataW-1] ^ b[DataW-1];
        unique case (i_beat.command)
            CMD_ADD:  n_cell.res = a + b;
            CMD_SUB:  n_cell.res = a - b;
            CMD_MUL:  n_cell.res = prod_sh[DataW-1:0];
            CMD_DIV: begin
                n_cell.is_div = (b != '0);
                n_cell.dz     = (b == '0);
            end
            CMD_GT:   n_cell.truth = a > b;
            CMD_LT:   n_cell.truth = a < b;
            CMD_GE:   n_cell.truth = a >= b;
            CMD_LE:   n_cell.truth = a <= b;
            CMD_EQ:   n_cell.truth = a == b;
            CMD_NE:   n_cell.truth = a != b;
            CMD_MIN:  n_cell.res = (a < b) ? a : b;
            CMD_MAX:  n_cell.res = (a > b) ? a : b;
            CMD_INC:  n_cell.res = a + 1'b1;
            CMD_DEC:  n_cell.res = a - 1'b1;
            CMD_FINT: n_cell.res = a << FracBits;
            CMD_TINT: n_cell.res = a >>> FracBits;
            default:  n_cell.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

>>> hdl/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell: one restoring-divide step
// Shifts one dividend bit into the remainder and sets one quotient bit.
// ----------------------------------------------------------------------------
module fpa_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  fpa_pkg::t_cell i_cell,
    output fpa_pkg::t_cell o_cell
);
    import fpa_pkg::*;

    logic [DataW:0]   shifted;
    logic [DataW+1:0] diff;
    t_cell            n_cell, r_cell;

    assign shifted = {i_cell.rem[DataW-1:0], i_cell.num[NumW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, i_cell.div};

    always_comb begin
        n_cell = i_cell;
        if (i_cell.is_div) begin
            n_cell.rem = diff[DataW+1] ? shifted : diff[DataW:0];
            n_cell.num = {i_cell.num[NumW-2:0], ~diff[DataW+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

>>> hdl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: signed Q24.8 arithmetic unit
// Decode cell, chain of 40 divide cells, then sign fix and output register.
// ----------------------------------------------------------------------------
//  channel  | signals                  | direction
//  in       | i_valid/o_ready/i_data   | beat into the unit
//  out      | o_valid/i_ready/o_data   | beat out of the unit
//
// Every command takes one beat per cycle while the chain is not held;
// Stages+2 = 42 register stages, and all commands, not only divides, pass
// through the divide chain of one quotient bit per cell.
// The whole chain advances together; it holds when the output register is
// full and not taken. Synchronous active-low reset clears all valid bits.
// ----------------------------------------------------------------------------
module fixed_point_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fpa_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output fpa_pkg::t_out_beat o_data
);
    import fpa_pkg::*;

    t_cell              chain [0:Stages];
    logic               en;
    logic [NumW-1:0]    qneg;
    logic [DataW-1:0]   q;
    t_cell              last;
    logic               r_valid;
    t_out_beat          r_data;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_beat  (i_data),
        .o_cell  (chain[0])
    );

    for (genvar g = 0; g < Stages; g++) begin : g_cell
        fpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (chain[g]),
            .o_cell  (chain[g+1])
        );
    end

    assign last = chain[Stages];
    assign qneg = ~last.num + 1'b1;
    assign q    = last.neg ? qneg[DataW-1:0] : last.num[DataW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data.result         <= last.is_div ? q : last.res;
            r_data.truth          <= last.truth;
            r_data.divide_by_zero <= last.dz;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker: port-level checks for the fixed-point ALU
// Output handshake stability, input readiness and result-field consistency.
// ----------------------------------------------------------------------------
module fpa_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_ready,
    input  logic               o_valid,
    input  logic               i_ready,
    input  fpa_pkg::t_out_beat o_data
);
    import fpa_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat dropped while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.divide_by_zero |-> o_data.result == '0 && !o_data.truth)
        else $error("divide by zero with nonzero fields");

    a_truth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.truth |-> o_data.result == '0)
        else $error("comparison with nonzero result");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
